/* rtl/core/dlt_pkg.sv */
// shared constants for the delimiter line tokenizer: result kinds,
// line-end modes, control bytes and register indexes; no dependencies
`default_nettype none

package dlt_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned KindWidth   = 2;
   localparam int unsigned LengthWidth = 16;
   localparam int unsigned ModeWidth   = 2;
   localparam int unsigned CountWidth  = 3;
   localparam int unsigned IndexWidth  = 3;
   localparam int unsigned NumDelims   = 4;

   localparam logic [ByteWidth-1:0] ByteLf = 8'd10;
   localparam logic [ByteWidth-1:0] ByteCr = 8'd13;

   localparam logic [KindWidth-1:0] KindSkip  = 2'd0;
   localparam logic [KindWidth-1:0] KindByte  = 2'd1;
   localparam logic [KindWidth-1:0] KindDelim = 2'd2;
   localparam logic [KindWidth-1:0] KindEol   = 2'd3;

   localparam logic [ModeWidth-1:0] ModeLf   = 2'd0;
   localparam logic [ModeWidth-1:0] ModeCrlf = 2'd2;

   localparam logic [IndexWidth-1:0] RegLineEndMode   = 3'd0;
   localparam logic [IndexWidth-1:0] RegDelimiterCnt  = 3'd1;
   localparam logic [IndexWidth-1:0] RegDelimiterA    = 3'd2;
   localparam logic [IndexWidth-1:0] RegDelimiterB    = 3'd3;
   localparam logic [IndexWidth-1:0] RegDelimiterC    = 3'd4;
   localparam logic [IndexWidth-1:0] RegDelimiterD    = 3'd5;

   localparam logic [CountWidth-1:0] CountReset  = 3'd1;
   localparam logic [ByteWidth-1:0]  DelimAReset = 8'd32;

endpackage

`default_nettype wire

/* rtl/core/delimiter_line_tokenizer.sv */
// delimiter line tokenizer top level: byte classification, parser state
// and result register; depends on dlt_pkg
`default_nettype none

// Takes one byte per beat and returns exactly one result beat per byte: skipped,
// token byte, token ended by a delimiter, or line end with the token length
// (saturating at 65535). Each byte is classified against
// the configured delimiters and the parser state in a single pass and lands in
// the result register, so a new byte is taken every cycle while the result side
// keeps up; req_ready drops only while a result waits and rsp_ready is low.
// Configuration writes are always taken (csr_ready is tied high) and should be
// made only while no bytes are in flight.
module delimiter_line_tokenizer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [dlt_pkg::ByteWidth-1:0]       req_in_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [dlt_pkg::KindWidth-1:0]            rsp_kind,
   output logic [dlt_pkg::ByteWidth-1:0]            rsp_out_byte,
   output logic [dlt_pkg::LengthWidth-1:0]          rsp_token_length,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dlt_pkg::IndexWidth-1:0]      csr_index,
   input  wire logic [dlt_pkg::ByteWidth-1:0]       csr_data
);
   import dlt_pkg::*;

   typedef enum logic [1:0] {
      PhaseIdle   = 2'd0,
      PhaseToken  = 2'd1,
      PhaseCrWait = 2'd2
   } phase_type;

   logic [ModeWidth-1:0]   mode_ff;
   logic [CountWidth-1:0]  count_ff;
   logic [ByteWidth-1:0]   delim_ff [NumDelims];

   phase_type              phase_ff, phase_in;
   logic [LengthWidth-1:0] length_ff, length_in;

   logic                   rsp_valid_ff;
   logic [KindWidth-1:0]   kind_ff, kind_in;
   logic [ByteWidth-1:0]   byte_ff, byte_in;
   logic [LengthWidth-1:0] rlen_ff, rlen_in;

   logic                   accept;
   logic                   is_delim, is_lf, is_cr, eol_start, crlf;
   logic [NumDelims-1:0]   delim_hit;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_token_length = rlen_ff;

   // configuration registers, widths already match the fields
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ModeLf;
         count_ff    <= CountReset;
         delim_ff[0] <= DelimAReset;
         delim_ff[1] <= '0;
         delim_ff[2] <= '0;
         delim_ff[3] <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            RegLineEndMode:  mode_ff     <= csr_data[ModeWidth-1:0];
            RegDelimiterCnt: count_ff    <= csr_data[CountWidth-1:0];
            RegDelimiterA:   delim_ff[0] <= csr_data;
            RegDelimiterB:   delim_ff[1] <= csr_data;
            RegDelimiterC:   delim_ff[2] <= csr_data;
            RegDelimiterD:   delim_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // counts above four use all four registers
   always_comb begin
      for (int i = 0; i < NumDelims; i++) begin
         delim_hit[i] = (delim_ff[i] == req_in_byte)
                        && ((count_ff > CountWidth'(i)) || count_ff[CountWidth-1]);
      end
   end

   assign is_delim  = (req_in_byte == '0) || (|delim_hit);
   assign is_lf     = (req_in_byte == ByteLf);
   assign is_cr     = (req_in_byte == ByteCr);
   assign eol_start = (is_lf && mode_ff == ModeLf) || (is_cr && mode_ff != ModeLf);
   assign crlf      = (mode_ff == ModeCrlf);

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      kind_in   = KindSkip;
      byte_in   = '0;
      rlen_in   = '0;
      case (phase_ff)
         PhaseCrWait: begin
            if (is_lf) begin
               kind_in   = KindEol;
               rlen_in   = length_ff;
               phase_in  = PhaseIdle;
               length_in = '0;
            end
         end
         PhaseToken: begin
            if (!is_delim && !eol_start) begin
               kind_in = KindByte;
               byte_in = req_in_byte;
               if (length_ff != '1) length_in = length_ff + 1'b1;
            end else if (is_lf && mode_ff == ModeLf) begin
               kind_in   = KindEol;
               rlen_in   = length_ff;
               phase_in  = PhaseIdle;
               length_in = '0;
            end else if (is_cr && mode_ff != ModeLf) begin
               if (crlf) begin
                  // keep the length for the line end at the LF
                  phase_in = PhaseCrWait;
               end else begin
                  kind_in   = KindEol;
                  rlen_in   = length_ff;
                  phase_in  = PhaseIdle;
                  length_in = '0;
               end
            end else begin
               kind_in   = KindDelim;
               rlen_in   = length_ff;
               phase_in  = PhaseIdle;
               length_in = '0;
            end
         end
         default: begin
            phase_in  = PhaseIdle;
            length_in = '0;
            if (is_delim && !eol_start) begin
               kind_in = KindSkip;
            end else if (is_lf && mode_ff == ModeLf) begin
               kind_in = KindEol;
            end else if (is_cr) begin
               // stray cr in lf mode is eaten
               if (mode_ff == ModeLf) begin
                  kind_in = KindSkip;
               end else if (crlf) begin
                  phase_in = PhaseCrWait;
               end else begin
                  kind_in = KindEol;
               end
            end else begin
               kind_in   = KindByte;
               byte_in   = req_in_byte;
               phase_in  = PhaseToken;
               length_in = LengthWidth'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhaseIdle;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            length_ff <= length_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         rlen_ff <= rlen_in;
      end
   end

endmodule

`default_nettype wire

/* sim/tb_delimiter_line_tokenizer.sv */
// testbench for the delimiter line tokenizer: drives byte beats, predicts each
// result beat and checks it field by field; depends on dlt_pkg and the top level
`timescale 1ns / 1ps

module tb_delimiter_line_tokenizer;
   import dlt_pkg::*;

   localparam int ResetCycles = 7;
   localparam int DrainCycles = 3;
   localparam int HoldCycles  = 300;
   localparam int BytesPerSetting = 100;
   localparam int TimeoutNs   = 4_000_000;

   localparam logic [ModeWidth-1:0]  ModeCr     = 2'd1;
   localparam logic [ModeWidth-1:0]  ModeSpare  = 2'd3;
   localparam logic [IndexWidth-1:0] RegSpareLo = 3'd6;
   localparam logic [IndexWidth-1:0] RegSpareHi = 3'd7;
   localparam logic [ByteWidth-1:0]  ByteNul    = 8'h00;

   typedef enum logic [1:0] {
      PhaseIdle   = 2'd0,
      PhaseToken  = 2'd1,
      PhaseCrWait = 2'd2
   } parse_phase_type;

   typedef struct packed {
      logic [KindWidth-1:0]   kind;
      logic [ByteWidth-1:0]   data;
      logic [LengthWidth-1:0] length;
   } tok_event_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ByteWidth-1:0]   req_in_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [KindWidth-1:0]   rsp_kind;
   logic [ByteWidth-1:0]   rsp_out_byte;
   logic [LengthWidth-1:0] rsp_token_length;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [IndexWidth-1:0]  csr_index = '0;
   logic [ByteWidth-1:0]   csr_data = '0;

   // shadow of the block's registers and parser state
   logic [ModeWidth-1:0]   line_mode = ModeLf;
   logic [CountWidth-1:0]  delim_cnt = CountReset;
   logic [ByteWidth-1:0]   delim_val [NumDelims] = '{DelimAReset, 8'h00, 8'h00, 8'h00};
   parse_phase_type        phase = PhaseIdle;
   logic [LengthWidth-1:0] tok_len = '0;

   tok_event_type token_events_q[$];
   int  bytes_sent = 0;
   int  error_count = 0;
   int  tx_idle_pct = 0;
   int  rx_stall_pct = 0;
   logic hold_active = 1'b0;
   event hold_start;

   delimiter_line_tokenizer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_token_length (rsp_token_length),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TimeoutNs);
      $display("FAILURE");
      $finish;
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic is_separator(input logic [ByteWidth-1:0] c);
      int  n;
      logic hit;
      n = (delim_cnt > NumDelims) ? NumDelims : delim_cnt;
      hit = (c == ByteNul);
      for (int i = 0; i < n; i++)
         if (delim_val[i] == c) hit = 1'b1;
      return hit;
   endfunction

   // advances the shadow parser by one byte and returns the beat it yields
   function automatic tok_event_type tokenize_byte(input logic [ByteWidth-1:0] c);
      tok_event_type ev;
      logic [LengthWidth-1:0] len;
      logic sep;
      logic eol;
      ev = '0;
      ev.kind = KindSkip;
      len = tok_len;
      sep = is_separator(c);
      eol = (c == ByteLf) ? (line_mode == ModeLf) :
            (c == ByteCr) ? (line_mode != ModeLf) : 1'b0;
      if (phase == PhaseCrWait) begin
         // everything up to the LF is swallowed, whatever the mode now
         if (c == ByteLf) begin
            ev.kind = KindEol;
            ev.length = len;
            phase = PhaseIdle;
            tok_len = '0;
         end
      end else if (phase == PhaseToken) begin
         if (!sep && !eol) begin
            if (tok_len != '1) tok_len = tok_len + 1'b1;
            ev.kind = KindByte;
            ev.data = c;
         end else if (c == ByteCr && line_mode == ModeCrlf) begin
            phase = PhaseCrWait;
         end else begin
            ev.kind = eol ? KindEol : KindDelim;
            ev.length = len;
            phase = PhaseIdle;
            tok_len = '0;
         end
      end else begin
         phase = PhaseIdle;
         tok_len = '0;
         if (sep && !eol) begin
            ev.kind = KindSkip;
         end else if (c == ByteLf && line_mode == ModeLf) begin
            ev.kind = KindEol;
         end else if (c == ByteCr) begin
            if (line_mode == ModeCrlf) phase = PhaseCrWait;
            else if (line_mode != ModeLf) ev.kind = KindEol;
         end else begin
            phase = PhaseToken;
            tok_len = LengthWidth'(1);
            ev.kind = KindByte;
            ev.data = c;
         end
      end
      return ev;
   endfunction

   task automatic send_byte(input logic [ByteWidth-1:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      token_events_q.push_back(tokenize_byte(b));
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic write_reg(input logic [IndexWidth-1:0] idx, input logic [ByteWidth-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         RegLineEndMode:  line_mode = val[ModeWidth-1:0];
         RegDelimiterCnt: delim_cnt = val[CountWidth-1:0];
         RegDelimiterA:   delim_val[0] = val;
         RegDelimiterB:   delim_val[1] = val;
         RegDelimiterC:   delim_val[2] = val;
         RegDelimiterD:   delim_val[3] = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [ModeWidth-1:0] mode, input logic [CountWidth-1:0] cnt,
                               input logic [ByteWidth-1:0] a, input logic [ByteWidth-1:0] b,
                               input logic [ByteWidth-1:0] c, input logic [ByteWidth-1:0] d);
      write_reg(RegLineEndMode, ByteWidth'(mode));
      write_reg(RegDelimiterCnt, ByteWidth'(cnt));
      write_reg(RegDelimiterA, a);
      write_reg(RegDelimiterB, b);
      write_reg(RegDelimiterC, c);
      write_reg(RegDelimiterD, d);
   endtask

   // stop sending and wait until every byte has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (token_events_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [ByteWidth-1:0] pick_token_byte();
      logic [ByteWidth-1:0] b;
      do begin
         if ($urandom_range(7) == 0) b = ByteWidth'($urandom_range(255));
         else b = ByteWidth'($urandom_range(8'h21, 8'h7e));
      end while (is_separator(b) || b == ByteLf || b == ByteCr);
      return b;
   endfunction

   function automatic logic [ByteWidth-1:0] pick_sep_byte();
      int n;
      n = (delim_cnt > NumDelims) ? NumDelims : delim_cnt;
      if (n == 0 || $urandom_range(3) == 0) return ByteNul;
      return delim_val[$urandom_range(n - 1)];
   endfunction

   function automatic logic [ByteWidth-1:0] draw_delim_value();
      case ($urandom_range(6))
         0: return 8'h20;   // space
         1: return 8'h09;   // tab
         2: return 8'h2c;   // comma
         3: return ByteLf;
         4: return ByteCr;
         5: return ByteNul;
         default: return ByteWidth'($urandom_range(255));
      endcase
   endfunction

   // one line of words, with some noise and the odd broken line end
   task automatic send_line();
      repeat ($urandom_range(0, 4)) begin
         repeat ($urandom_range(0, 2)) send_byte(pick_sep_byte());
         repeat ($urandom_range(1, 6)) send_byte(pick_token_byte());
      end
      if ($urandom_range(99) < 20)
         repeat ($urandom_range(1, 3)) send_byte(ByteWidth'($urandom_range(255)));
      if (line_mode == ModeLf && $urandom_range(99) < 15) send_byte(ByteCr);
      if (line_mode == ModeLf) begin
         send_byte(ByteLf);
      end else if (line_mode == ModeCrlf) begin
         send_byte(ByteCr);
         if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 3)) send_byte(ByteWidth'($urandom_range(255)));
         if ($urandom_range(99) < 90) send_byte(ByteLf);
      end else begin
         send_byte(ByteCr);
      end
   endtask

   task automatic test_reset_config();
      send_text("ab c");
      send_byte(ByteLf);
      send_byte(8'hff);
      send_byte(ByteNul);     // zero byte always ends a token
      send_byte(ByteCr);      // stray CR while idle is eaten
      send_text("x");
      send_byte(ByteCr);      // CR is a plain token byte in LF mode
      send_byte(ByteLf);
   endtask

   task automatic test_line_ends();
      settle();
      // LF becomes an ordinary delimiter, CR ends the line
      apply_config(ModeCr, 3'd2, 8'h20, ByteLf, ByteNul, ByteNul);
      send_text("a");
      send_byte(ByteLf);
      send_text("b");
      send_byte(ByteCr);
      settle();
      // CR then junk then LF, then an empty CRLF line
      apply_config(ModeCrlf, 3'd0, 8'h20, ByteNul, ByteNul, ByteNul);
      send_text("ab");
      send_byte(ByteCr);
      send_text("z");
      send_byte(ByteLf);
      send_byte(ByteCr);
      send_byte(ByteLf);
      settle();
      // spare mode acts as CR, count above four uses all four registers
      apply_config(ModeSpare, 3'd7, 8'h20, ByteNul, 8'hff, 8'h2c);
      send_text("q,");
      send_byte(ByteCr);
      settle();
      // CR configured as delimiter ends a token in LF mode
      apply_config(ModeLf, 3'd2, 8'h20, ByteCr, ByteNul, ByteNul);
      write_reg(RegSpareLo, 8'hff);
      write_reg(RegSpareHi, 8'hff);
      send_text("ab");
      send_byte(ByteCr);
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct);
      int start;
      logic [CountWidth-1:0] cnt;
      tx_idle_pct = tx_pct;
      rx_stall_pct = rx_pct;
      repeat (2) begin
         settle();
         if ($urandom_range(3) == 0) cnt = CountWidth'($urandom_range(7));
         else cnt = CountWidth'($urandom_range(1, 4));
         apply_config(ModeWidth'($urandom_range(3)), cnt, draw_delim_value(),
                      draw_delim_value(), draw_delim_value(), draw_delim_value());
         start = bytes_sent;
         while (bytes_sent - start < BytesPerSetting) send_line();
      end
   endtask

   task automatic test_backpressure();
      int start;
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      settle();
      -> hold_start;
      start = bytes_sent;
      while (bytes_sent - start < 40) send_line();
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      for (int i = 0; i < 2000 && token_events_q.size() != 0; i++) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (token_events_q.size() != 0)
         report_error($sformatf("%0d result beats never arrived", token_events_q.size()));
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   endtask

   // long receiver hold-off, counted here so the sender keeps pushing
   initial begin
      forever begin
         @(hold_start);
         hold_active <= 1'b1;
         repeat (HoldCycles) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !hold_active && ($urandom_range(99) >= rx_stall_pct);
   end

   always @(posedge clock) begin : check_results
      tok_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (token_events_q.size() == 0) begin
            report_error("result beat with nothing outstanding");
         end else begin
            want = token_events_q.pop_front();
            if (rsp_kind !== want.kind)
               report_error($sformatf("kind got %0d want %0d", rsp_kind, want.kind));
            if (rsp_out_byte !== want.data)
               report_error($sformatf("out_byte got %02h want %02h", rsp_out_byte, want.data));
            if (rsp_token_length !== want.length)
               report_error($sformatf("token_length got %0d want %0d",
                                      rsp_token_length, want.length));
         end
      end
   end

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_line_ends();
      test_random_traffic(0, 0);
      test_random_traffic(56, 0);
      test_random_traffic(0, 56);
      test_random_traffic(28, 28);
      test_backpressure();
      finish_run();
   end

endmodule

/* sim.f */
rtl/core/dlt_pkg.sv
rtl/core/delimiter_line_tokenizer.sv
sim/tb_delimiter_line_tokenizer.sv
